@@ sv/bls_pkg.sv @@
`default_nettype none

package bls_pkg;

    // default number of stack cells
    localparam int BLS_DEPTH = 16;

    // width of the size limit register
    localparam int LIMIT_W = 5;

    // reset value of the size limit register
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    typedef logic signed [31:0] bls_word_t;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_POP     = 2'd1,
        OP_DISPLAY = 2'd2,
        OP_PEEK    = 2'd3
    } bls_op_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_OVERFLOW = 2'd1,
        STS_EMPTY    = 2'd2,
        STS_BADPOS   = 2'd3
    } bls_status_t;

    // request word
    typedef struct packed {
        bls_op_t    opcode;
        bls_word_t  value;
        logic [7:0] position;
    } bls_in_t;

    // response word
    typedef struct packed {
        bls_word_t   data;
        bls_status_t status;
        logic        last;
    } bls_out_t;

    // shift commands broadcast along the cell row
    typedef struct packed {
        logic push;
        logic pop;
        logic rotate;
    } bls_cell_ctl_t;

endpackage

`default_nettype wire

@@ sv/bounded_lifo_stack_unit.sv @@
// channel | direction | handshake             | word
// --------+-----------+-----------------------+----------------------------------
// req     | in        | req_valid / req_ready | bls_in_t  opcode, value, position
// rsp     | out       | rsp_valid / rsp_ready | bls_out_t data, status, last
// cfg     | in        | cfg_we (no wait)      | cfg_wdata size limit
//
// push, pop and peek give one response each; display gives count responses,
// one per cycle unless rsp stalls, by rotating the top count cells once each.
// a request is taken when idle and the response register is empty or draining.
// reset empties the stack and sets the size limit to 16; cell contents are
// not cleared. a stalled response holds the block; display pauses with it.
`default_nettype none

module bounded_lifo_stack_unit #(
    parameter int DEPTH = bls_pkg::BLS_DEPTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire bls_pkg::bls_in_t            req,
    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    output bls_pkg::bls_out_t                rsp,
    input  wire logic                        cfg_we,
    input  wire logic [bls_pkg::LIMIT_W-1:0] cfg_wdata
);
    import bls_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_DISP
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   remain_reg;
    logic [CNT_W-1:0]   remain_next;
    logic [LIMIT_W-1:0] size_limit_reg;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    bls_out_t           rsp_reg;
    bls_out_t           rsp_next;

    bls_cell_ctl_t      ctl;
    bls_word_t          cell_data [DEPTH];
    bls_word_t          cell_peek [DEPTH];
    logic [DEPTH-1:0]   wrap_sel;
    logic [DEPTH-1:0]   peek_sel;
    bls_word_t          peek_data;

    logic               out_free;
    logic               accept;
    logic               push_ok;
    logic               pos_ok;
    logic [7:0]         cnt8;
    logic [7:0]         pos_m1;
    logic [CNT_W-1:0]   count_m1;

    // limit and position checks
    assign cnt8     = 8'(count_reg);
    assign push_ok  = (cnt8 < 8'(size_limit_reg)) && (count_reg != CNT_W'(DEPTH));
    assign pos_ok   = (req.position != 8'd0) && (req.position <= cnt8);
    assign pos_m1   = req.position - 8'd1;
    assign count_m1 = count_reg - CNT_W'(1);

    // row of cells, cell 0 holds the top of the stack
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        bls_word_t up_w;
        bls_word_t dn_w;

        if (i == 0)
        begin : g_first
            assign up_w = req.value;
        end
        else
        begin : g_mid_up
            assign up_w = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_end
            assign dn_w = '0;
        end
        else
        begin : g_mid_dn
            assign dn_w = cell_data[i+1];
        end

        assign wrap_sel[i] = (count_m1 == CNT_W'(i));
        assign peek_sel[i] = pos_ok && (pos_m1 == 8'(i));

        bls_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .up_data   (up_w),
            .dn_data   (dn_w),
            .top_data  (cell_data[0]),
            .wrap_sel  (wrap_sel[i]),
            .peek_sel  (peek_sel[i]),
            .data      (cell_data[i]),
            .peek_data (cell_peek[i])
        );
    end

    // gather the selected peek word
    always_comb
    begin
        peek_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            peek_data = peek_data | cell_peek[i];
        end
    end

    // handshake
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req_valid && req_ready;

    // next state, response word and cell commands
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        ctl            = '0;

        if (accept)
        begin
            rsp_valid_next = 1'b1;
            unique case (req.opcode)
                OP_PUSH:
                begin
                    if (push_ok)
                    begin
                        ctl.push   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        rsp_next   = '{data: req.value, status: STS_OK, last: 1'b1};
                    end
                    else
                    begin
                        rsp_next = '{data: '0, status: STS_OVERFLOW, last: 1'b1};
                    end
                end
                OP_POP:
                begin
                    if (count_reg != '0)
                    begin
                        ctl.pop    = 1'b1;
                        count_next = count_m1;
                        rsp_next   = '{data: cell_data[0], status: STS_OK, last: 1'b1};
                    end
                    else
                    begin
                        rsp_next = '{data: '0, status: STS_EMPTY, last: 1'b1};
                    end
                end
                OP_DISPLAY:
                begin
                    if (count_reg != '0)
                    begin
                        ctl.rotate  = 1'b1;
                        remain_next = count_m1;
                        rsp_next    = '{data: cell_data[0], status: STS_OK,
                                        last: (count_reg == CNT_W'(1))};
                        if (count_reg != CNT_W'(1))
                        begin
                            state_next = ST_DISP;
                        end
                    end
                    else
                    begin
                        rsp_next = '{data: '0, status: STS_EMPTY, last: 1'b1};
                    end
                end
                OP_PEEK:
                begin
                    if (pos_ok)
                    begin
                        rsp_next = '{data: peek_data, status: STS_OK, last: 1'b1};
                    end
                    else
                    begin
                        rsp_next = '{data: '0, status: STS_BADPOS, last: 1'b1};
                    end
                end
            endcase
        end
        else if (state_reg == ST_DISP && out_free)
        begin
            // stream the next word and rotate it to the bottom of the live range
            ctl.rotate     = 1'b1;
            rsp_valid_next = 1'b1;
            remain_next    = remain_reg - CNT_W'(1);
            rsp_next       = '{data: cell_data[0], status: STS_OK,
                               last: (remain_reg == CNT_W'(1))};
            if (remain_reg == CNT_W'(1))
            begin
                state_next = ST_IDLE;
            end
        end
    end

    // control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            remain_reg     <= '0;
            size_limit_reg <= LIMIT_RESET;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                size_limit_reg <= cfg_wdata;
            end
        end
    end

    // response payload, no reset needed
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // fill level never passes the number of cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("stack count above depth");

    // no request is taken while a display is streaming
    a_disp_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DISP) |-> !req_ready)
        else $error("request ready during display");

    // a word that is not the last one only exists mid display
    a_nonlast_disp: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.last) |-> (state_reg == ST_DISP))
        else $error("non-last word outside display");

    // fill level moves only on an accepted request
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> (count_reg == $past(count_reg)))
        else $error("count changed without a request");
`endif

endmodule

`default_nettype wire

@@ sv/bls_cell.sv @@
`default_nettype none

module bls_cell (
    input  wire logic                   clk,
    input  wire bls_pkg::bls_cell_ctl_t ctl,
    input  wire bls_pkg::bls_word_t     up_data,
    input  wire bls_pkg::bls_word_t     dn_data,
    input  wire bls_pkg::bls_word_t     top_data,
    input  wire logic                   wrap_sel,
    input  wire logic                   peek_sel,
    output bls_pkg::bls_word_t          data,
    output bls_pkg::bls_word_t          peek_data
);
    import bls_pkg::*;

    bls_word_t data_reg;
    bls_word_t data_next;

    // push moves words down, pop moves them up, rotate wraps the top word
    always_comb
    begin
        data_next = data_reg;
        if (ctl.push)
        begin
            data_next = up_data;
        end
        else if (ctl.pop)
        begin
            data_next = dn_data;
        end
        else if (ctl.rotate)
        begin
            data_next = wrap_sel ? top_data : dn_data;
        end
    end

    // payload storage, no reset needed
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    assign peek_data = peek_sel ? data_reg : '0;

endmodule

`default_nettype wire
